// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg - shared types and constants of the double-ended queue
// operation codes, error codes, store geometry and control bundle
// ----------------------------------------------------------------------------
package deq_pkg;

  // store geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // transaction field widths
  localparam int MODE_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int ERR_W   = 2;
  localparam int COUNT_W = 5;

  // byte reported when nothing is popped or the queue is empty
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'd32;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming transaction
    logic exec;      // apply the operation to pointers and store
    logic load_out;  // load the result register
  } deq_cmd_t;

endpackage

// ----- design/deq_if.sv -----
// ----------------------------------------------------------------------------
// deq_if - valid/ready channels of the double-ended queue
// request channel and result channel with source and sink views
// ----------------------------------------------------------------------------
interface deq_in_if
  import deq_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface deq_out_if
  import deq_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  popped_value;
  logic [ERR_W-1:0]   error_code;
  logic [COUNT_W-1:0] item_count;
  logic               is_empty;
  logic [BYTE_W-1:0]  front_value;
  logic [BYTE_W-1:0]  rear_value;

  modport source (output valid, output popped_value, output error_code,
                  output item_count, output is_empty, output front_value,
                  output rear_value, input ready);
  modport sink   (input valid, input popped_value, input error_code,
                  input item_count, input is_empty, input front_value,
                  input rear_value, output ready);
endinterface

// ----- design/double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_unit - byte deque with push/pop at both ends
// top level joining the sequencer and the store datapath
// ----------------------------------------------------------------------------
// usage
//   in_ch  : request transaction, mode (push front, push rear, pop front,
//            pop rear, clear) and the byte to push
//   out_ch : one result transaction per request, popped byte, error code,
//            count, empty flag and the front and rear bytes after the op
// timing
//   a request is taken only while the unit is idle; it then passes an
//   execute step (store write, pointer update), a status step re-reading
//   the front and rear entries and a done step loading the result
//   register; the next request is taken only after that load
//   the status step is set by the registered read ports of the byte store
// reset
//   rst_n clears the head pointer, the count and the sequencer; store
//   contents stay as they are and are read only after being written
// backpressure
//   the result register holds while out_ch.ready is low; the next request
//   is still taken and waits in the last step until the register frees
// ----------------------------------------------------------------------------
module double_ended_queue_unit
  import deq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  deq_in_if.sink   in_ch,
  deq_out_if.source out_ch
);

  deq_cmd_t cmd;

  // sequencer
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // store, pointers and result register
  deq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_ch.mode),
    .in_push_value    (in_ch.push_value),
    .out_popped_value (out_ch.popped_value),
    .out_error_code   (out_ch.error_code),
    .out_item_count   (out_ch.item_count),
    .out_is_empty     (out_ch.is_empty),
    .out_front_value  (out_ch.front_value),
    .out_rear_value   (out_ch.rear_value)
  );

endmodule

// ----- design/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl - sequencer of the double-ended queue
// steps one transaction through execute, status read and result load
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output deq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STAT,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  assign cmd.capture  = in_valid && in_ready;
  assign cmd.exec     = (state_r == ST_EXEC);
  assign cmd.load_out = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_STAT;
      ST_STAT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // one transaction in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("new transaction taken while one is in flight");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_ready |=> state_r == ST_DONE)
    else $error("result loaded over a pending one");

endmodule

// ----- design/deq_dp.sv -----
// ----------------------------------------------------------------------------
// deq_dp - datapath of the double-ended queue
// byte store, head pointer, fill count and result register
// ----------------------------------------------------------------------------
module deq_dp
  import deq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  deq_cmd_t           cmd,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [BYTE_W-1:0]  in_push_value,
  output logic [BYTE_W-1:0]  out_popped_value,
  output logic [ERR_W-1:0]   out_error_code,
  output logic [COUNT_W-1:0] out_item_count,
  output logic               out_is_empty,
  output logic [BYTE_W-1:0]  out_front_value,
  output logic [BYTE_W-1:0]  out_rear_value
);

  // wrap head + offset into the store, offset below CAPACITY
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [BYTE_W-1:0] mem [CAPACITY];

  logic [MODE_W-1:0] mode_r;
  logic [BYTE_W-1:0] value_r;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] rd_front_r, rd_rear_r;
  logic [BYTE_W-1:0] popped_r, popped_nxt;
  err_t              err_r, err_nxt;

  logic [IDX_W-1:0]  rear_idx;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic              full, empty;

  logic [BYTE_W-1:0] res_popped_r;
  err_t              res_err_r;
  logic [CNT_W-1:0]  res_count_r;
  logic              res_empty_r;
  logic [BYTE_W-1:0] res_front_r, res_rear_r;

  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign rear_idx = empty ? head_r : slot(head_r, count_r - CNT_W'(1));

  // operation decode
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    popped_nxt = SPACE_BYTE;
    err_nxt    = ERR_OK;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    case (mode_r)
      OP_PUSH_FRONT: begin
        if (full) begin
          err_nxt = ERR_FULL;
        end else begin
          head_nxt  = slot(head_r, CNT_W'(CAPACITY - 1));
          wr_en     = 1'b1;
          wr_addr   = head_nxt;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          err_nxt = ERR_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = slot(head_r, count_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          err_nxt = ERR_EMPTY;
        end else begin
          popped_nxt = rd_front_r;
          head_nxt   = slot(head_r, CNT_W'(1));
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          err_nxt = ERR_EMPTY;
        end else begin
          popped_nxt = rd_rear_r;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  // byte store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    rd_front_r <= mem[head_r];
    rd_rear_r  <= mem[rear_idx];
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= value_r;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      value_r <= in_push_value;
    end
    if (cmd.exec) begin
      popped_r <= popped_nxt;
      err_r    <= err_nxt;
    end
    if (cmd.load_out) begin
      res_popped_r <= popped_r;
      res_err_r    <= err_r;
      res_count_r  <= count_r;
      res_empty_r  <= empty;
      res_front_r  <= empty ? SPACE_BYTE : rd_front_r;
      res_rear_r   <= empty ? SPACE_BYTE : rd_rear_r;
    end
  end

  assign out_popped_value = res_popped_r;
  assign out_error_code   = res_err_r;
  assign out_item_count   = COUNT_W'(res_count_r);
  assign out_is_empty     = res_empty_r;
  assign out_front_value  = res_front_r;
  assign out_rear_value   = res_rear_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (err_nxt != ERR_OK) |=>
      $stable(count_r) && $stable(head_r))
    else $error("rejected operation moved the pointers");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (mode_r == OP_CLEAR) |=> (count_r == '0) && (head_r == '0))
    else $error("clear left pointers set");

endmodule
